[sv/qrv_pkg.sv]
// Shared types and constants for the quaternion vector rotation block.
package qrv_pkg;

	localparam int NUM_AX = 3;
	localparam int ADDR_W = 4;
	localparam int RAD_W = 62;
	localparam int ROOT_W = 31;
	localparam int REM_W = 33;
	localparam int DREM_W = 31;

	localparam logic [15:0] QUAT_W_RESET = 16'h4000;

	typedef enum logic [1:0] {
		REG_QUAT_X = 2'd0,
		REG_QUAT_Y = 2'd1,
		REG_QUAT_Z = 2'd2,
		REG_QUAT_W = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic signed [15:0] vec_x;
		logic signed [15:0] vec_y;
		logic signed [15:0] vec_z;
	} vec_t;

	typedef struct packed {
		logic signed [15:0] rot_x;
		logic signed [15:0] rot_y;
		logic signed [15:0] rot_z;
		logic zero_input;
	} rot_t;

	typedef struct packed {
		logic [NUM_AX-1:0][DREM_W-1:0] mag_sh;
		logic [NUM_AX-1:0] neg;
		logic zero;
	} sq_side_t;

	typedef struct packed {
		logic [NUM_AX-1:0] neg;
		logic zero;
	} div_side_t;

endpackage

[sv/quaternion_rotate_vector.sv]
// Top level of the quaternion vector rotation pipeline with its register port.
// A word is accepted whenever start is high, since busy never rises, and each word
// gives one result word, marked by done for one cycle. The vector is normalized
// by the 31-stage square root and the FRAC_BITS + 1 stage divider. Results cannot
// be held off, so every word flows straight through. The quaternion registers are
// read live by the product stages and should only be written while no word is in
// flight.
module quaternion_rotate_vector #(
	parameter int FRAC_BITS = 14
) (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  qrv_pkg::vec_t vec,
	output logic done,
	output qrv_pkg::rot_t result,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [qrv_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	localparam int LN = qrv_pkg::NUM_AX;
	localparam int VQ_W = FRAC_BITS + 2;
	localparam int P1_W = VQ_W + 17;
	localparam int S1_W = P1_W + 2;
	localparam int T_W = 19;
	localparam int P2_W = 16 + T_W;
	localparam int S2_W = P2_W + 2;
	localparam int N_W = FRAC_BITS + 32;
	localparam int SQ_SIDE_W = $bits(qrv_pkg::sq_side_t);
	localparam int DIV_SIDE_W = $bits(qrv_pkg::div_side_t);
	localparam longint SAT_HI = (FRAC_BITS >= 15) ? 32767 : (longint'(1) << FRAC_BITS);
	localparam longint SAT_LO = (FRAC_BITS >= 15) ? -32768 : -(longint'(1) << FRAC_BITS);
	localparam logic signed [S1_W-1:0] HALF1 =
		{{(S1_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
	localparam logic signed [S2_W-1:0] HALF2 =
		{{(S2_W-FRAC_BITS){1'b0}}, 1'b1, {(FRAC_BITS-1){1'b0}}};
	localparam logic [FRAC_BITS:0] UNIT = {1'b1, {FRAC_BITS{1'b0}}};

	logic [3:0][15:0] quat_q;
	logic cfg_wr;

	assign pready = 1'b1;
	assign busy = 1'b0;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quat_q[qrv_pkg::REG_QUAT_X] <= '0;
			quat_q[qrv_pkg::REG_QUAT_Y] <= '0;
			quat_q[qrv_pkg::REG_QUAT_Z] <= '0;
			quat_q[qrv_pkg::REG_QUAT_W] <= qrv_pkg::QUAT_W_RESET;
		end else if (cfg_wr) begin
			case (qrv_pkg::reg_idx_t'(paddr[3:2]))
				qrv_pkg::REG_QUAT_X: quat_q[qrv_pkg::REG_QUAT_X] <= pwdata[15:0];
				qrv_pkg::REG_QUAT_Y: quat_q[qrv_pkg::REG_QUAT_Y] <= pwdata[15:0];
				qrv_pkg::REG_QUAT_Z: quat_q[qrv_pkg::REG_QUAT_Z] <= pwdata[15:0];
				qrv_pkg::REG_QUAT_W: quat_q[qrv_pkg::REG_QUAT_W] <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	assign prdata = {16'h0000, quat_q[paddr[3:2]]};

	logic signed [15:0] qx, qy, qz, qw;
	logic signed [16:0] cqx, cqy, cqz, cqw;

	assign qx = quat_q[qrv_pkg::REG_QUAT_X];
	assign qy = quat_q[qrv_pkg::REG_QUAT_Y];
	assign qz = quat_q[qrv_pkg::REG_QUAT_Z];
	assign qw = quat_q[qrv_pkg::REG_QUAT_W];
	assign cqx = -17'(qx);
	assign cqy = -17'(qy);
	assign cqz = -17'(qz);
	assign cqw = 17'(qw);

	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5;
	logic vld_s6, vld_s7, vld_s8, vld_s9, vld_s10, vld_s11;
	qrv_pkg::vec_t vec_s1;
	logic [LN-1:0][30:0] sq_s2;
	logic [LN-1:0][15:0] mag_s2, mag_s3, mag_s4;
	logic [LN-1:0] neg_s2, neg_s3, neg_s4;
	logic [31:0] m_s3, m_s4;
	logic [4:0] k_s4;
	logic zero_s4;
	logic [qrv_pkg::RAD_W-1:0] rad_s5;
	qrv_pkg::sq_side_t side_s5;

	logic [LN-1:0][15:0] vin;
	assign vin = {vec_s1.vec_z, vec_s1.vec_y, vec_s1.vec_x};

	logic [LN-1:0][30:0] sq_c;
	logic [LN-1:0][15:0] mag_c;
	always_comb begin
		logic signed [31:0] prod;
		for (int i = 0; i < LN; i++) begin
			prod = $signed(vin[i]) * $signed(vin[i]);
			sq_c[i] = prod[30:0];
			mag_c[i] = vin[i][15] ? (16'h0000 - vin[i]) : vin[i];
		end
	end

	logic [4:0] lead_c;
	logic [5:0] kdiff_c;
	always_comb begin
		lead_c = '0;
		for (int b = 0; b < 32; b++) begin
			if (m_s3[b]) lead_c = 5'(b);
		end
		kdiff_c = 6'd61 - {1'b0, lead_c};
	end

	logic [qrv_pkg::RAD_W-1:0] rad_c;
	logic [LN-1:0][qrv_pkg::DREM_W-1:0] ash_c;
	always_comb begin
		logic [45:0] wide;
		rad_c = {30'b0, m_s4} << {k_s4, 1'b0};
		for (int i = 0; i < LN; i++) begin
			wide = {30'b0, mag_s4[i]} << k_s4;
			ash_c[i] = wide[qrv_pkg::DREM_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		vec_s1 <= vec;
		sq_s2 <= sq_c;
		mag_s2 <= mag_c;
		for (int i = 0; i < LN; i++) neg_s2[i] <= vin[i][15];
		m_s3 <= 32'(sq_s2[0]) + 32'(sq_s2[1]) + 32'(sq_s2[2]);
		mag_s3 <= mag_s2;
		neg_s3 <= neg_s2;
		m_s4 <= m_s3;
		k_s4 <= kdiff_c[5:1];
		zero_s4 <= (m_s3 == 32'd0);
		mag_s4 <= mag_s3;
		neg_s4 <= neg_s3;
		rad_s5 <= rad_c;
		side_s5.mag_sh <= ash_c;
		side_s5.neg <= neg_s4;
		side_s5.zero <= zero_s4;
	end

	logic sq_vld;
	logic [qrv_pkg::ROOT_W-1:0] sq_root;
	qrv_pkg::sq_side_t sq_side;

	qrv_sqrt #(
		.SIDE_W(SQ_SIDE_W)
	) u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(vld_s5),
		.in_rad(rad_s5),
		.in_side(side_s5),
		.out_valid(sq_vld),
		.out_root(sq_root),
		.out_side(sq_side)
	);

	logic [LN-1:0][N_W-1:0] num_s6;
	logic [qrv_pkg::DREM_W-1:0] dvs_s6;
	qrv_pkg::div_side_t side_s6;
	logic [LN-1:0][qrv_pkg::DREM_W-1:0] drem_c;
	logic [LN-1:0][FRAC_BITS:0] dlow_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= sq_vld;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < LN; i++) begin
			num_s6[i] <= (N_W'(sq_side.mag_sh[i]) << FRAC_BITS) +
				N_W'(sq_root[qrv_pkg::ROOT_W-1:1]);
		end
		dvs_s6 <= sq_root;
		side_s6.neg <= sq_side.neg;
		side_s6.zero <= sq_side.zero;
	end

	always_comb begin
		for (int i = 0; i < LN; i++) begin
			drem_c[i] = num_s6[i][N_W-1:FRAC_BITS+1];
			dlow_c[i] = num_s6[i][FRAC_BITS:0];
		end
	end

	logic dv_vld;
	logic [LN-1:0][FRAC_BITS:0] dv_quo;
	qrv_pkg::div_side_t dv_side;

	qrv_div #(
		.FRAC_BITS(FRAC_BITS),
		.SIDE_W(DIV_SIDE_W)
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(vld_s6),
		.in_rem(drem_c),
		.in_low(dlow_c),
		.in_dvs(dvs_s6),
		.in_side(side_s6),
		.out_valid(dv_vld),
		.out_quo(dv_quo),
		.out_side(dv_side)
	);

	logic signed [VQ_W-1:0] vq_s7 [LN];
	logic zero_s7, zero_s8, zero_s9, zero_s10;
	logic signed [P1_W-1:0] p1_s8 [12];
	logic signed [T_W-1:0] t_s9 [4];
	logic signed [P2_W-1:0] p2_s10 [12];
	qrv_pkg::rot_t res_s11;
	logic vld_out_s11;

	logic signed [VQ_W-1:0] vq_c [LN];
	always_comb begin
		logic [FRAC_BITS:0] n;
		for (int i = 0; i < LN; i++) begin
			n = (dv_quo[i] > UNIT) ? UNIT : dv_quo[i];
			vq_c[i] = dv_side.neg[i] ? -VQ_W'(n) : VQ_W'(n);
		end
	end

	logic signed [T_W-1:0] t_c [4];
	always_comb begin
		logic signed [S1_W-1:0] sum [4];
		logic signed [S1_W-1:0] rnd;
		sum[0] = S1_W'(p1_s8[0]) + S1_W'(p1_s8[1]) - S1_W'(p1_s8[2]);
		sum[1] = S1_W'(p1_s8[3]) + S1_W'(p1_s8[4]) - S1_W'(p1_s8[5]);
		sum[2] = S1_W'(p1_s8[6]) + S1_W'(p1_s8[7]) - S1_W'(p1_s8[8]);
		sum[3] = -S1_W'(p1_s8[9]) - S1_W'(p1_s8[10]) - S1_W'(p1_s8[11]);
		for (int i = 0; i < 4; i++) begin
			rnd = (sum[i] + HALF1) >>> FRAC_BITS;
			t_c[i] = rnd[T_W-1:0];
		end
	end

	qrv_pkg::rot_t res_c;
	always_comb begin
		logic signed [S2_W-1:0] sum [LN];
		logic signed [S2_W-1:0] rnd;
		logic signed [15:0] o [LN];
		sum[0] = S2_W'(p2_s10[0]) + S2_W'(p2_s10[1]) + S2_W'(p2_s10[2]) - S2_W'(p2_s10[3]);
		sum[1] = S2_W'(p2_s10[4]) + S2_W'(p2_s10[5]) + S2_W'(p2_s10[6]) - S2_W'(p2_s10[7]);
		sum[2] = S2_W'(p2_s10[8]) + S2_W'(p2_s10[9]) + S2_W'(p2_s10[10]) - S2_W'(p2_s10[11]);
		for (int i = 0; i < LN; i++) begin
			rnd = (sum[i] + HALF2) >>> FRAC_BITS;
			if (zero_s10) begin
				o[i] = '0;
			end else if (rnd > S2_W'(SAT_HI)) begin
				o[i] = 16'(SAT_HI);
			end else if (rnd < S2_W'(SAT_LO)) begin
				o[i] = 16'(SAT_LO);
			end else begin
				o[i] = rnd[15:0];
			end
		end
		res_c.rot_x = o[0];
		res_c.rot_y = o[1];
		res_c.rot_z = o[2];
		res_c.zero_input = zero_s10;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
			vld_s10 <= 1'b0;
			vld_s11 <= 1'b0;
		end else begin
			vld_s7 <= dv_vld;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
			vld_s10 <= vld_s9;
			vld_s11 <= vld_s10;
		end
	end

	always_ff @(posedge clk) begin
		vq_s7 <= vq_c;
		zero_s7 <= dv_side.zero;
		p1_s8[0] <= P1_W'(vq_s7[0]) * P1_W'(cqw);
		p1_s8[1] <= P1_W'(vq_s7[1]) * P1_W'(cqz);
		p1_s8[2] <= P1_W'(vq_s7[2]) * P1_W'(cqy);
		p1_s8[3] <= P1_W'(vq_s7[1]) * P1_W'(cqw);
		p1_s8[4] <= P1_W'(vq_s7[2]) * P1_W'(cqx);
		p1_s8[5] <= P1_W'(vq_s7[0]) * P1_W'(cqz);
		p1_s8[6] <= P1_W'(vq_s7[2]) * P1_W'(cqw);
		p1_s8[7] <= P1_W'(vq_s7[0]) * P1_W'(cqy);
		p1_s8[8] <= P1_W'(vq_s7[1]) * P1_W'(cqx);
		p1_s8[9] <= P1_W'(vq_s7[0]) * P1_W'(cqx);
		p1_s8[10] <= P1_W'(vq_s7[1]) * P1_W'(cqy);
		p1_s8[11] <= P1_W'(vq_s7[2]) * P1_W'(cqz);
		zero_s8 <= zero_s7;
		t_s9 <= t_c;
		zero_s9 <= zero_s8;
		p2_s10[0] <= P2_W'(qw) * P2_W'(t_s9[0]);
		p2_s10[1] <= P2_W'(qx) * P2_W'(t_s9[3]);
		p2_s10[2] <= P2_W'(qy) * P2_W'(t_s9[2]);
		p2_s10[3] <= P2_W'(qz) * P2_W'(t_s9[1]);
		p2_s10[4] <= P2_W'(qw) * P2_W'(t_s9[1]);
		p2_s10[5] <= P2_W'(qy) * P2_W'(t_s9[3]);
		p2_s10[6] <= P2_W'(qz) * P2_W'(t_s9[0]);
		p2_s10[7] <= P2_W'(qx) * P2_W'(t_s9[2]);
		p2_s10[8] <= P2_W'(qw) * P2_W'(t_s9[2]);
		p2_s10[9] <= P2_W'(qz) * P2_W'(t_s9[3]);
		p2_s10[10] <= P2_W'(qx) * P2_W'(t_s9[1]);
		p2_s10[11] <= P2_W'(qy) * P2_W'(t_s9[0]);
		zero_s10 <= zero_s9;
		res_s11 <= res_c;
	end

	assign vld_out_s11 = vld_s11;
	assign done = vld_out_s11;
	assign result = res_s11;

	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.zero_input |->
			result.rot_x == 16'sd0 && result.rot_y == 16'sd0 && result.rot_z == 16'sd0)
		else $error("zero input word gave a nonzero result");

	a_result_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> longint'(result.rot_x) <= SAT_HI && longint'(result.rot_x) >= SAT_LO &&
			longint'(result.rot_y) <= SAT_HI && longint'(result.rot_y) >= SAT_LO &&
			longint'(result.rot_z) <= SAT_HI && longint'(result.rot_z) >= SAT_LO)
		else $error("result component outside the saturation range");

	a_cfg_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_wr |=> $stable(quat_q))
		else $error("quaternion register changed without a write");

endmodule

[sv/qrv_sqrt.sv]
// Pipelined integer square root, one result bit per stage.
module qrv_sqrt #(
	parameter int SIDE_W = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic [qrv_pkg::RAD_W-1:0] in_rad,
	input  logic [SIDE_W-1:0] in_side,
	output logic out_valid,
	output logic [qrv_pkg::ROOT_W-1:0] out_root,
	output logic [SIDE_W-1:0] out_side
);

	localparam int STEPS = qrv_pkg::ROOT_W;
	localparam int RW = qrv_pkg::REM_W;
	localparam int OW = qrv_pkg::ROOT_W;
	localparam int DW = qrv_pkg::RAD_W;

	logic vld_s [STEPS];
	logic [RW-1:0] rem_s [STEPS];
	logic [OW-1:0] root_s [STEPS];
	logic [DW-1:0] rad_s [STEPS];
	logic [SIDE_W-1:0] side_s [STEPS];

	logic vld_n [STEPS];
	logic [RW-1:0] rem_n [STEPS];
	logic [OW-1:0] root_n [STEPS];
	logic [DW-1:0] rad_n [STEPS];
	logic [SIDE_W-1:0] side_n [STEPS];

	always_comb begin
		logic [RW-1:0] rem_c;
		logic [OW-1:0] root_c;
		logic [DW-1:0] rad_c;
		logic [RW+1:0] cand;
		logic [RW+1:0] diff;
		logic [RW-1:0] trial;
		for (int j = 0; j < STEPS; j++) begin
			if (j == 0) begin
				vld_n[j] = in_valid;
				rem_c = '0;
				root_c = '0;
				rad_c = in_rad;
				side_n[j] = in_side;
			end else begin
				vld_n[j] = vld_s[j-1];
				rem_c = rem_s[j-1];
				root_c = root_s[j-1];
				rad_c = rad_s[j-1];
				side_n[j] = side_s[j-1];
			end
			cand = {rem_c, rad_c[DW-1:DW-2]};
			trial = {root_c, 2'b01};
			diff = cand - {2'b00, trial};
			if (cand >= {2'b00, trial}) begin
				rem_n[j] = diff[RW-1:0];
				root_n[j] = {root_c[OW-2:0], 1'b1};
			end else begin
				rem_n[j] = cand[RW-1:0];
				root_n[j] = {root_c[OW-2:0], 1'b0};
			end
			rad_n[j] = {rad_c[DW-3:0], 2'b00};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < STEPS; j++) vld_s[j] <= 1'b0;
		end else begin
			for (int j = 0; j < STEPS; j++) vld_s[j] <= vld_n[j];
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < STEPS; j++) begin
			rem_s[j] <= rem_n[j];
			root_s[j] <= root_n[j];
			rad_s[j] <= rad_n[j];
			side_s[j] <= side_n[j];
		end
	end

	assign out_valid = vld_s[STEPS-1];
	assign out_root = root_s[STEPS-1];
	assign out_side = side_s[STEPS-1];

endmodule

[sv/qrv_div.sv]
// Pipelined restoring divider for the three vector lanes, one quotient bit per stage.
module qrv_div #(
	parameter int FRAC_BITS = 14,
	parameter int SIDE_W = 1
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	input  logic [qrv_pkg::NUM_AX-1:0][qrv_pkg::DREM_W-1:0] in_rem,
	input  logic [qrv_pkg::NUM_AX-1:0][FRAC_BITS:0] in_low,
	input  logic [qrv_pkg::DREM_W-1:0] in_dvs,
	input  logic [SIDE_W-1:0] in_side,
	output logic out_valid,
	output logic [qrv_pkg::NUM_AX-1:0][FRAC_BITS:0] out_quo,
	output logic [SIDE_W-1:0] out_side
);

	localparam int STEPS = FRAC_BITS + 1;
	localparam int LN = qrv_pkg::NUM_AX;
	localparam int RW = qrv_pkg::DREM_W;

	logic vld_s [STEPS];
	logic [LN-1:0][RW-1:0] rem_s [STEPS];
	logic [LN-1:0][FRAC_BITS:0] low_s [STEPS];
	logic [LN-1:0][FRAC_BITS:0] quo_s [STEPS];
	logic [RW-1:0] dvs_s [STEPS];
	logic [SIDE_W-1:0] side_s [STEPS];

	logic vld_n [STEPS];
	logic [LN-1:0][RW-1:0] rem_n [STEPS];
	logic [LN-1:0][FRAC_BITS:0] low_n [STEPS];
	logic [LN-1:0][FRAC_BITS:0] quo_n [STEPS];
	logic [RW-1:0] dvs_n [STEPS];
	logic [SIDE_W-1:0] side_n [STEPS];

	always_comb begin
		logic [LN-1:0][RW-1:0] rem_c;
		logic [LN-1:0][FRAC_BITS:0] low_c;
		logic [LN-1:0][FRAC_BITS:0] quo_c;
		logic [RW:0] cand;
		logic [RW:0] diff;
		for (int j = 0; j < STEPS; j++) begin
			if (j == 0) begin
				vld_n[j] = in_valid;
				rem_c = in_rem;
				low_c = in_low;
				quo_c = '0;
				dvs_n[j] = in_dvs;
				side_n[j] = in_side;
			end else begin
				vld_n[j] = vld_s[j-1];
				rem_c = rem_s[j-1];
				low_c = low_s[j-1];
				quo_c = quo_s[j-1];
				dvs_n[j] = dvs_s[j-1];
				side_n[j] = side_s[j-1];
			end
			for (int l = 0; l < LN; l++) begin
				cand = {rem_c[l], low_c[l][FRAC_BITS]};
				diff = cand - {1'b0, dvs_n[j]};
				if (cand >= {1'b0, dvs_n[j]}) begin
					rem_n[j][l] = diff[RW-1:0];
					quo_n[j][l] = {quo_c[l][FRAC_BITS-1:0], 1'b1};
				end else begin
					rem_n[j][l] = cand[RW-1:0];
					quo_n[j][l] = {quo_c[l][FRAC_BITS-1:0], 1'b0};
				end
				low_n[j][l] = {low_c[l][FRAC_BITS-1:0], 1'b0};
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < STEPS; j++) vld_s[j] <= 1'b0;
		end else begin
			for (int j = 0; j < STEPS; j++) vld_s[j] <= vld_n[j];
		end
	end

	always_ff @(posedge clk) begin
		for (int j = 0; j < STEPS; j++) begin
			rem_s[j] <= rem_n[j];
			low_s[j] <= low_n[j];
			quo_s[j] <= quo_n[j];
			dvs_s[j] <= dvs_n[j];
			side_s[j] <= side_n[j];
		end
	end

	assign out_valid = vld_s[STEPS-1];
	assign out_quo = quo_s[STEPS-1];
	assign out_side = side_s[STEPS-1];

endmodule
